### design/hsed_pkg.sv
package hsed_pkg;

   localparam logic [7:0] MARK_BYTE       = 8'hFF;
   localparam logic [7:0] PARITY_BYTE     = 8'h00;
   localparam logic [1:0] LAST_HEADER_POS = 2'd3;

   typedef enum logic [2:0] {
      REG_HEADER_ZERO    = 3'd0,
      REG_HEADER_ONE     = 3'd1,
      REG_HEADER_TWO     = 3'd2,
      REG_HEADER_THREE   = 3'd3,
      REG_PAYLOAD_LENGTH = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      EV_DATA     = 2'd0,
      EV_MISALIGN = 2'd1,
      EV_PARITY   = 2'd2,
      EV_BADESC   = 2'd3
   } event_kind_type;

   typedef struct packed {
      logic [3:0][7:0] header;
      logic [7:0]      payload_length;
   } csr_type;

   typedef struct packed {
      event_kind_type kind;
      logic [7:0]     value;
      logic [7:0]     index;
      logic           last;
   } result_type;

endpackage

### design/hsed_csr.sv
module hsed_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [2:0]        csr_index,
   input  logic [7:0]        csr_write_data,
   output hsed_pkg::csr_type csr
);
   import hsed_pkg::*;

   csr_type csr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.header         <= '0;
         csr_ff.payload_length <= 8'd1;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            REG_HEADER_ZERO:    csr_ff.header[0]      <= csr_write_data;
            REG_HEADER_ONE:     csr_ff.header[1]      <= csr_write_data;
            REG_HEADER_TWO:     csr_ff.header[2]      <= csr_write_data;
            REG_HEADER_THREE:   csr_ff.header[3]      <= csr_write_data;
            REG_PAYLOAD_LENGTH: csr_ff.payload_length <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign csr = csr_ff;

endmodule

### design/hsed_parser.sv
module hsed_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           rx_byte,
   input  hsed_pkg::csr_type    csr,
   output logic                 has_result,
   output hsed_pkg::result_type result
);
   import hsed_pkg::*;

   typedef enum logic [1:0] {
      MODE_HEADER  = 2'd0,
      MODE_PAYLOAD = 2'd1,
      MODE_MARK    = 2'd2,
      MODE_PARITY  = 2'd3
   } mode_type;

   mode_type   mode_ff, mode_in;
   logic [7:0] position_ff, position_in;
   logic [7:0] next_position;
   logic       payload_last;

   assign next_position = position_ff + 8'd1;
   assign payload_last  = (next_position == csr.payload_length);

   always_comb begin
      mode_in      = mode_ff;
      position_in  = position_ff;
      has_result   = 1'b0;
      result.kind  = EV_DATA;
      result.value = rx_byte;
      result.index = 8'd0;
      result.last  = 1'b0;
      case (mode_ff)
         MODE_HEADER: begin
            if (rx_byte == csr.header[position_ff[1:0]]) begin
               if (position_ff[1:0] == LAST_HEADER_POS) begin
                  position_in = 8'd0;
                  mode_in     = MODE_PAYLOAD;
               end else begin
                  position_in = {6'd0, position_ff[1:0] + 2'd1};
               end
            end else begin
               // restart the match; this byte is not retried as header byte zero
               position_in = 8'd0;
               has_result  = 1'b1;
               result.kind = EV_MISALIGN;
            end
         end
         MODE_PAYLOAD, MODE_MARK: begin
            if (mode_ff == MODE_PAYLOAD && rx_byte == MARK_BYTE) begin
               mode_in = MODE_MARK;
            end else if (mode_ff == MODE_MARK && rx_byte == PARITY_BYTE) begin
               mode_in = MODE_PARITY;
            end else if (mode_ff == MODE_MARK && rx_byte != MARK_BYTE) begin
               position_in = 8'd0;
               mode_in     = MODE_HEADER;
               has_result  = 1'b1;
               result.kind = EV_BADESC;
            end else begin
               // plain payload byte, or an escaped mark
               has_result   = 1'b1;
               result.index = position_ff;
               result.last  = payload_last;
               position_in  = payload_last ? 8'd0 : next_position;
               mode_in      = payload_last ? MODE_HEADER : MODE_PAYLOAD;
            end
         end
         default: begin
            // drop the byte after FF 00 and resync
            position_in = 8'd0;
            mode_in     = MODE_HEADER;
            has_result  = 1'b1;
            result.kind = EV_PARITY;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_HEADER;
         position_ff <= 8'd0;
      end else if (accept) begin
         mode_ff     <= mode_in;
         position_ff <= position_in;
      end
   end

endmodule

### design/hsed_rsp_reg.sv
module hsed_rsp_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  hsed_pkg::result_type result,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output hsed_pkg::result_type rsp_result,
   output logic                 can_load
);
   import hsed_pkg::*;

   logic       valid_ff;
   result_type result_ff;

   // free when empty, or when the held result leaves this cycle
   assign can_load = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

### design/header_sync_escape_deframer_core.sv
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  req_rx_byte
// rsp       out        rsp_valid/rsp_ready  rsp_event_kind, rsp_byte_value,
//                                           rsp_byte_index, rsp_last_of_packet
// csr       in         csr_write_enable     csr_index, csr_write_data
//
// One received byte per cycle while req_ready is high; a result is registered and then appears.
// The parser state and the compare against the header registers feed
// combinational logic ahead of a single result register.
// Synchronous reset returns the parser to header search, position 0, and
// empties the result register; registers go to zero headers and length 1.
// A held result stalls req only if rsp_ready is low in that cycle.
module header_sync_escape_deframer_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_event_kind,
   output logic [7:0] rsp_byte_value,
   output logic [7:0] rsp_byte_index,
   output logic       rsp_last_of_packet,
   input  logic       csr_write_enable,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_write_data
);
   import hsed_pkg::*;

   csr_type    csr;
   result_type result;
   result_type rsp_result;
   logic       accept;
   logic       has_result;
   logic       can_load;

   // take a transaction whenever the result register can hold its outcome
   assign req_ready = can_load;
   assign accept    = req_valid && req_ready;

   hsed_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .csr              (csr)
   );

   hsed_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .rx_byte    (req_rx_byte),
      .csr        (csr),
      .has_result (has_result),
      .result     (result)
   );

   // load only bytes that raise an event or carry payload
   hsed_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (accept && has_result),
      .result     (result),
      .rsp_ready  (rsp_ready),
      .rsp_valid  (rsp_valid),
      .rsp_result (rsp_result),
      .can_load   (can_load)
   );

   assign rsp_event_kind     = rsp_result.kind;
   assign rsp_byte_value     = rsp_result.value;
   assign rsp_byte_index     = rsp_result.index;
   assign rsp_last_of_packet = rsp_result.last;

   // error events carry no packet position
   a_error_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind != EV_DATA |-> rsp_byte_index == 8'd0 && !rsp_last_of_packet)
      else $error("error event with non-zero index or last flag");

   // the final payload byte sits at index length minus one
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_packet |-> rsp_byte_index == csr.payload_length - 8'd1)
      else $error("last_of_packet at wrong index");

   // nothing leaves the block in the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

endmodule

### tb/tb_header_sync_escape_deframer_core.sv
module tb_header_sync_escape_deframer_core;
   timeunit 1ns;
   timeprecision 1ps;

   import hsed_pkg::*;

   // Unused register indexes; writes to them must leave the block untouched
   localparam logic [2:0] REG_SPARE_LOW  = 3'd5;
   localparam logic [2:0] REG_SPARE_HIGH = 3'd7;

   localparam int CYCLE_LIMIT    = 400000;
   localparam int REPORT_LIMIT   = 10;
   localparam int SETTLE_CYCLES  = 4;
   localparam int HOLD_OFF_LEN   = 120;
   localparam int PHASE_BYTES    = 60;
   localparam int RANDOM_PHASES  = 8;

   // Parser modes of the predictor
   typedef enum logic [1:0] {
      HUNT_HEADER  = 2'd0,
      COLLECT      = 2'd1,
      AFTER_MARK   = 2'd2,
      AWAIT_PARITY = 2'd3
   } parse_mode_type;

   // Fault kinds planted into generated packets
   typedef enum int {
      FAULT_NONE,
      FAULT_PARITY,
      FAULT_ESCAPE
   } fault_type;

   class deframe_scoreboard;
      logic [7:0]     header_bytes [4];
      logic [7:0]     length;
      parse_mode_type mode;
      logic [7:0]     position;
      result_type     expected_events [$];
      int             event_mismatches;

      function new();
         foreach (header_bytes[i]) header_bytes[i] = 8'h00;
         length           = 8'd1;
         mode             = HUNT_HEADER;
         position         = 8'd0;
         event_mismatches = 0;
      endfunction

      function void set_register(logic [2:0] idx, logic [7:0] data);
         case (idx)
            REG_HEADER_ZERO:    header_bytes[0] = data;
            REG_HEADER_ONE:     header_bytes[1] = data;
            REG_HEADER_TWO:     header_bytes[2] = data;
            REG_HEADER_THREE:   header_bytes[3] = data;
            REG_PAYLOAD_LENGTH: length = data;
            default: ;
         endcase
      endfunction

      function void push_event(event_kind_type kind, logic [7:0] value,
                               logic [7:0] index, logic last);
         result_type ev;
         ev.kind  = kind;
         ev.value = value;
         ev.index = index;
         ev.last  = last;
         expected_events.push_back(ev);
      endfunction

      // Emit one payload byte; the counter wraps at 8 bits
      function void push_payload(logic [7:0] value);
         logic [7:0] next_pos;
         logic       last;
         next_pos = position + 8'd1;
         last     = (next_pos == length);
         push_event(EV_DATA, value, position, last);
         if (last) begin
            position = 8'd0;
            mode     = HUNT_HEADER;
         end else begin
            position = next_pos;
            mode     = COLLECT;
         end
      endfunction

      function void note_rx_byte(logic [7:0] b);
         case (mode)
            HUNT_HEADER: begin
               if (b == header_bytes[position[1:0]]) begin
                  if (position[1:0] >= LAST_HEADER_POS) begin
                     position = 8'd0;
                     mode     = COLLECT;
                  end else begin
                     position = {6'd0, position[1:0] + 2'd1};
                  end
               end else begin
                  // restart the match; the offending byte is not retried
                  position = 8'd0;
                  push_event(EV_MISALIGN, b, 8'd0, 1'b0);
               end
            end
            COLLECT: begin
               if (b == MARK_BYTE) mode = AFTER_MARK;
               else push_payload(b);
            end
            AFTER_MARK: begin
               if (b == MARK_BYTE) begin
                  push_payload(b);
               end else if (b == PARITY_BYTE) begin
                  mode = AWAIT_PARITY;
               end else begin
                  position = 8'd0;
                  mode     = HUNT_HEADER;
                  push_event(EV_BADESC, b, 8'd0, 1'b0);
               end
            end
            default: begin
               // byte after the parity mark is reported and dropped
               position = 8'd0;
               mode     = HUNT_HEADER;
               push_event(EV_PARITY, b, 8'd0, 1'b0);
            end
         endcase
      endfunction

      function void check_event(result_type got);
         result_type want;
         if (expected_events.size() == 0) begin
            if (event_mismatches < REPORT_LIMIT)
               $display("unexpected event: kind %0d value %02h index %0d last %0b",
                        got.kind, got.value, got.index, got.last);
            event_mismatches++;
         end else begin
            want = expected_events.pop_front();
            if (got.kind !== want.kind || got.value !== want.value ||
                got.index !== want.index || got.last !== want.last) begin
               if (event_mismatches < REPORT_LIMIT)
                  $display({"event mismatch: expected kind %0d value %02h index %0d ",
                            "last %0b, got kind %0d value %02h index %0d last %0b"},
                           want.kind, want.value, want.index, want.last,
                           got.kind, got.value, got.index, got.last);
               event_mismatches++;
            end
         end
      endfunction

      function int pending();
         return expected_events.size();
      endfunction
   endclass

   logic       clock              = 1'b0;
   logic       reset              = 1'b1;
   logic       req_valid          = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte        = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready          = 1'b0;
   logic [1:0] rsp_event_kind;
   logic [7:0] rsp_byte_value;
   logic [7:0] rsp_byte_index;
   logic       rsp_last_of_packet;
   logic       csr_write_enable   = 1'b0;
   logic [2:0] csr_index          = 3'd0;
   logic [7:0] csr_write_data     = 8'h00;

   deframe_scoreboard frames = new();

   // Idling controls for the sender task and the receiver process
   int sender_idle_pct   = 0;
   int receiver_stall_pct = 0;
   int sender_calm_left  = 0;
   bit sender_calm       = 1'b0;
   int hold_off_cycles   = 0;   // loaded by the stimulus, counted down by the receiver
   int cycle_count       = 0;

   header_sync_escape_deframer_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_event_kind     (rsp_event_kind),
      .rsp_byte_value     (rsp_byte_value),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_last_of_packet (rsp_last_of_packet),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Watchdog: end the run as failed once the cycle limit is reached
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock) cycle_count++;
      $display("header_sync_escape_deframer_core test failed");
      $finish;
   end

   // Receiver: drive ready at the falling edge, take the transaction at the rising edge
   initial begin
      int  stretch_left;
      bit  calm;
      result_type got;
      stretch_left = 0;
      calm         = 1'b0;
      forever begin
         @(negedge clock);
         if (stretch_left == 0) begin
            stretch_left = 50;
            calm         = ($urandom_range(3) == 0);
         end
         stretch_left--;
         if (hold_off_cycles > 0) begin
            // long hold-off: let the result register fill and stall the input
            rsp_ready <= 1'b0;
            hold_off_cycles--;
         end else if (!calm && $urandom_range(99) < receiver_stall_pct) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.kind  = event_kind_type'(rsp_event_kind);
            got.value = rsp_byte_value;
            got.index = rsp_byte_index;
            got.last  = rsp_last_of_packet;
            frames.check_event(got);
         end
      end
   end

   // Offer one byte; hold valid and data until the transaction completes
   task automatic send_byte(input logic [7:0] b);
      if (sender_calm_left == 0) begin
         sender_calm_left = 40;
         sender_calm      = ($urandom_range(3) == 0);
      end
      sender_calm_left--;
      while (!sender_calm && $urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         req_valid   <= 1'b0;
         req_rx_byte <= 8'($urandom);
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      frames.note_rx_byte(b);
   endtask

   // Payload byte, with the mark doubled
   task automatic send_data(input logic [7:0] b, inout int sent);
      send_byte(b);
      sent++;
      if (b == MARK_BYTE) begin
         send_byte(MARK_BYTE);
         sent++;
      end
   endtask

   // Drop valid, wait for every expected event, then let the pipeline settle
   task automatic quiesce();
      @(negedge clock);
      req_valid <= 1'b0;
      while (frames.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [2:0] idx, input logic [7:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      frames.set_register(idx, data);
   endtask

   // Program all registers plus one spare index, then release the write enable
   task automatic apply_settings(input logic [7:0] h0, input logic [7:0] h1,
                                 input logic [7:0] h2, input logic [7:0] h3,
                                 input logic [7:0] len);
      write_register(3'($urandom_range(REG_SPARE_HIGH, REG_SPARE_LOW)), 8'($urandom));
      write_register(REG_HEADER_ZERO, h0);
      write_register(REG_HEADER_ONE, h1);
      write_register(REG_HEADER_TWO, h2);
      write_register(REG_HEADER_THREE, h3);
      write_register(REG_PAYLOAD_LENGTH, len);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // One framed packet with random content; may carry noise, a broken header,
   // an escape fault, or be cut short after cut_after payload bytes
   task automatic send_packet(input int cut_after, inout int sent);
      int        choice;
      int        bad_pos;
      int        count;
      int        fault_at;
      fault_type fault;
      logic [7:0] b;
      choice = $urandom_range(99);
      if (choice < 8) begin
         repeat ($urandom_range(3, 1)) begin
            send_byte(8'($urandom));
            sent++;
         end
         return;
      end
      bad_pos = (choice < 18) ? $urandom_range(3) : -1;
      for (int i = 0; i < 4; i++) begin
         if (i == bad_pos) begin
            send_byte(frames.header_bytes[i] ^ 8'($urandom_range(255, 1)));
            sent++;
            return;
         end
         send_byte(frames.header_bytes[i]);
         sent++;
      end
      count    = (frames.length == 8'd0) ? 256 : int'(frames.length);
      fault    = FAULT_NONE;
      fault_at = -1;
      if ($urandom_range(3) == 0) begin
         fault_at = $urandom_range(count - 1);
         fault    = ($urandom_range(1) == 0) ? FAULT_PARITY : FAULT_ESCAPE;
      end
      for (int k = 0; k < count; k++) begin
         if (k == cut_after) return;
         if (k == fault_at) begin
            send_byte(MARK_BYTE);
            sent++;
            if (fault == FAULT_PARITY) begin
               send_byte(PARITY_BYTE);
               send_byte(8'($urandom));
            end else begin
               send_byte(8'($urandom_range(8'hFE, 8'h01)));
            end
            sent += (fault == FAULT_PARITY) ? 2 : 1;
            return;
         end
         b = ($urandom_range(4) == 0) ? MARK_BYTE : 8'($urandom);
         send_data(b, sent);
      end
   endtask

   initial begin
      logic [7:0] opening [$];
      logic [7:0] h0, h1, h2, h3, len;
      int         sent;
      int         cut;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: four zero header bytes, one-byte packets
      opening = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h5A};
      foreach (opening[i]) send_byte(opening[i]);
      quiesce();

      // Directed: misalignment at the first and third header byte, doubled mark,
      // parity error and bad escape
      apply_settings(8'hA5, 8'h5A, 8'h00, 8'hFF, 8'd3);
      opening = '{8'h12,
                  8'hA5, 8'h5A, 8'h33,
                  8'hA5, 8'h5A, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00,
                  8'hFF, 8'h00, 8'h80,
                  8'hA5, 8'h5A, 8'h00, 8'hFF, 8'hFF, 8'h7E};
      foreach (opening[i]) send_byte(opening[i]);
      quiesce();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 62; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 62; end
            default: begin sender_idle_pct = 15; receiver_stall_pct = 15; end
         endcase
         h0  = 8'($urandom);
         h1  = 8'($urandom);
         h2  = 8'($urandom);
         h3  = 8'($urandom);
         len = 8'($urandom_range(8, 1));
         cut = -1;
         case (phase)
            1: begin h0 = 8'h00; h1 = 8'h00; h2 = 8'h00; h3 = 8'h00; len = 8'd1; end
            2: begin h0 = 8'hFF; h1 = 8'hFF; h2 = 8'hFF; h3 = 8'hFF; len = 8'd255; end
            3: len = 8'd0;   // counter wraps: 256-byte packets
            4: begin len = 8'd8; cut = 5; end
            5: len = 8'd3;   // shorter than the index left by the cut packet
            6: len = 8'($urandom_range(16, 1));
            7: begin h0 = 8'h00; h1 = 8'hFF; h2 = 8'h00; h3 = 8'hFF; end
            default: ;
         endcase
         // Phase 5 starts with the parser mid-packet, so leave the phase-4 state alone
         apply_settings(h0, h1, h2, h3, len);
         if (phase == 4) hold_off_cycles = HOLD_OFF_LEN;
         sent = 0;
         while (sent < PHASE_BYTES) send_packet(-1, sent);
         // leave a packet open across the next register write
         if (cut >= 0) begin
            for (int i = 0; i < 4; i++) send_byte(frames.header_bytes[i]);
            for (int k = 0; k < cut; k++) send_byte(8'($urandom_range(8'hFE, 8'h00)));
         end
         quiesce();
      end

      // Drain and give any stray event time to show up
      while (frames.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES * 2) @(posedge clock);

      if (frames.event_mismatches == 0 && frames.pending() == 0) begin
         $display("header_sync_escape_deframer_core test passed");
      end else begin
         $display("header_sync_escape_deframer_core test failed");
      end
      $finish;
   end

endmodule
